// ===== hw/rtl/ctg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions of the circle trajectory generator.
// It has no dependencies. The ROM and the top level import it.
package ctg_pkg;

  localparam int unsigned SineAddrBitsDef = 10;
  localparam int unsigned PhaseBitsDef    = 32;
  localparam int unsigned CfgAddrBits     = 2;
  localparam int unsigned CfgDataBits     = 32;

  // pi/2 in unsigned Q30.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam logic [31:0]        PhaseStepRst = 32'd2050696;
  localparam logic [15:0]        RadiusRst    = 16'd512;
  localparam logic signed [15:0] AltitudeRst  = 16'sd512;
  localparam logic [15:0]        AngleRateRst = 16'd1229;

  typedef enum logic [CfgAddrBits-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_RADIUS     = 2'd1,
    CFG_ALTITUDE   = 2'd2,
    CFG_ANGLE_RATE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FIN
  } ctg_state_e;

  // Sine of x in [0, pi/2], argument and result in unsigned Q30. Only ever
  // evaluated on constants while the table is built.
  function automatic logic [63:0] sin_q30(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    return sum;
  endfunction

  // Quarter-wave table entry k, sampled at the middle of each step, Q1.15.
  function automatic logic [15:0] qtab_entry(int unsigned k, int unsigned abits);
    logic [63:0] x;
    logic [63:0] v;
    x = (HalfPiQ30 * (64'(2 * k) + 64'd1)) >> (abits + 1);
    v = (sin_q30(x) + 64'd16384) >> 15;
    return v[15:0];
  endfunction

  // Round half away from zero, then clamp to the 24-bit signed range.
  function automatic logic [23:0] round_sat24(logic [63:0] mag, int unsigned shift, logic neg);
    logic [63:0] r;
    r = (mag + (64'd1 << (shift - 1))) >> shift;
    if (neg) begin
      if (r > 64'd8388608) begin
        r = 64'd8388608;
      end
      r = -r;
    end else if (r > 64'd8388607) begin
      r = 64'd8388607;
    end
    return r[23:0];
  endfunction

  // Position rounding; the magnitude can never exceed 65535.
  function automatic logic [16:0] round_pos(logic [31:0] mag, logic neg);
    logic [32:0] s;
    logic [16:0] r;
    s = (33'(mag) + 33'd16384) >> 15;
    r = s[16:0];
    return neg ? -r : r;
  endfunction

endpackage

// ===== hw/rtl/ctg_sine_rom.sv =====
`timescale 1ns / 1ps
// Quarter-wave sine ROM with two registered read ports.
// Contents are built from ctg_pkg::qtab_entry at elaboration.
module ctg_sine_rom #(
  parameter int unsigned AddrBits = ctg_pkg::SineAddrBitsDef
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] sin_addr_i,
  input  logic [AddrBits-1:0] cos_addr_i,
  output logic [15:0]         sin_o,
  output logic [15:0]         cos_o
);
  import ctg_pkg::*;

  localparam int unsigned Depth = 1 << AddrBits;

  logic [15:0] rom [Depth];
  logic [15:0] sin_q;
  logic [15:0] cos_q;

  for (genvar g = 0; g < Depth; g++) begin : g_rom
    assign rom[g] = qtab_entry(int'(g), AddrBits);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sin_q <= rom[sin_addr_i];
      cos_q <= rom[cos_addr_i];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== hw/rtl/circle_trajectory_generator.sv =====
`timescale 1ns / 1ps
// Circle trajectory generator: each accepted tick item with tick set yields one result item
// holding position, velocity and acceleration on a horizontal circle for the current phase,
// after which the phase advances by phase_step. A tick item with tick clear is accepted and
// yields nothing. From acceptance to the output register an item passes the registered
// quarter-wave ROM read at the accepting edge, then three multiply stages (R*w, R*w*w and
// the split wide products) and one rounding stage. The input is stalled until the rounding
// stage has finished, so no new item is taken while one is in flight. A finished result
// waits in the output register while the next item is computed; only a second finished
// result waits for it. Depends on ctg_pkg and ctg_sine_rom.
module circle_trajectory_generator #(
  parameter int unsigned SINE_ADDR_BITS = ctg_pkg::SineAddrBitsDef,
  parameter int unsigned PHASE_BITS     = ctg_pkg::PhaseBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ctg_pkg::CfgAddrBits-1:0]   cfg_addr_i,
  input  logic [ctg_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              tick_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [16:0]                pos_x_o,
  output logic signed [16:0]                pos_y_o,
  output logic signed [15:0]                pos_z_o,
  output logic signed [23:0]                vel_x_o,
  output logic signed [23:0]                vel_y_o,
  output logic signed [23:0]                acc_x_o,
  output logic signed [23:0]                acc_y_o
);
  import ctg_pkg::*;

  localparam int unsigned IdxBits = SINE_ADDR_BITS + 2;
  localparam int unsigned SumBits = (PHASE_BITS > 32) ? PHASE_BITS : 32;

  // Configuration registers.
  logic [31:0]        phase_step_q;
  logic [15:0]        radius_q;
  logic signed [15:0] altitude_q;
  logic [15:0]        angle_rate_q;

  ctg_state_e state_q, state_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [SumBits-1:0]    phase_sum;

  logic [IdxBits-1:0]        idx;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] k_idx;
  logic [SINE_ADDR_BITS-1:0] kr_idx;
  logic                      in_acc;
  logic                      go;
  logic                      out_load;

  logic [15:0] sin_mag;
  logic [15:0] cos_mag;

  // Datapath registers.
  logic        sneg_q, cneg_q;
  logic [31:0] pc_q, ps_q, rw_q;
  logic [47:0] vs_q, vc_q, rww_q;
  logic [47:0] alo_s_q, alo_c_q;
  logic [31:0] ahi_s_q, ahi_c_q;
  logic [63:0] acc_s_mag, acc_c_mag;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic signed [16:0] pos_x_q, pos_y_q;
  logic signed [15:0] pos_z_q;
  logic signed [23:0] vel_x_q, vel_y_q, acc_x_q, acc_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PhaseStepRst;
      radius_q     <= RadiusRst;
      altitude_q   <= AltitudeRst;
      angle_rate_q <= AngleRateRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_PHASE_STEP: phase_step_q <= cfg_wdata_i[31:0];
        CFG_RADIUS:     radius_q     <= cfg_wdata_i[15:0];
        CFG_ALTITUDE:   altitude_q   <= signed'(cfg_wdata_i[15:0]);
        CFG_ANGLE_RATE: angle_rate_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign go         = in_acc && tick_i;

  // Table address and quadrant come straight from the phase register.
  assign idx    = phase_q[PHASE_BITS-1 -: IdxBits];
  assign quad   = idx[IdxBits-1 -: 2];
  assign k_idx  = idx[SINE_ADDR_BITS-1:0];
  assign kr_idx = ~k_idx;

  assign phase_sum = SumBits'(phase_q) + SumBits'(phase_step_q);
  assign phase_d   = go ? phase_sum[PHASE_BITS-1:0] : phase_q;

  ctg_sine_rom #(
    .AddrBits(SINE_ADDR_BITS)
  ) u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (go),
    .sin_addr_i(quad[0] ? kr_idx : k_idx),
    .cos_addr_i(quad[0] ? k_idx : kr_idx),
    .sin_o     (sin_mag),
    .cos_o     (cos_mag)
  );

  always_comb begin
    state_d     = state_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (go) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      sneg_q <= quad[1];
      cneg_q <= quad[1] ^ quad[0];
    end
    if (state_q == ST_MUL1) begin
      pc_q <= 32'(radius_q) * 32'(cos_mag);
      ps_q <= 32'(radius_q) * 32'(sin_mag);
      rw_q <= 32'(radius_q) * 32'(angle_rate_q);
    end
    if (state_q == ST_MUL2) begin
      vs_q  <= 48'(rw_q) * 48'(sin_mag);
      vc_q  <= 48'(rw_q) * 48'(cos_mag);
      rww_q <= 48'(rw_q) * 48'(angle_rate_q);
    end
    // The 48 by 16 bit products are split at bit 32 and joined in the last stage.
    if (state_q == ST_MUL3) begin
      alo_s_q <= 48'(rww_q[31:0]) * 48'(sin_mag);
      alo_c_q <= 48'(rww_q[31:0]) * 48'(cos_mag);
      ahi_s_q <= 32'(rww_q[47:32]) * 32'(sin_mag);
      ahi_c_q <= 32'(rww_q[47:32]) * 32'(cos_mag);
    end
  end

  assign acc_s_mag = {ahi_s_q, 32'd0} + 64'(alo_s_q);
  assign acc_c_mag = {ahi_c_q, 32'd0} + 64'(alo_c_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_x_q <= signed'(round_pos(pc_q, cneg_q));
      pos_y_q <= signed'(round_pos(ps_q, sneg_q));
      pos_z_q <= altitude_q;
      vel_x_q <= signed'(round_sat24(64'(vs_q), 27, !sneg_q));
      vel_y_q <= signed'(round_sat24(64'(vc_q), 27, cneg_q));
      acc_x_q <= signed'(round_sat24(acc_c_mag, 39, !cneg_q));
      acc_y_q <= signed'(round_sat24(acc_s_mag, 39, !sneg_q));
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;
  assign vel_x_o     = vel_x_q;
  assign vel_y_o     = vel_y_q;
  assign acc_x_o     = acc_x_q;
  assign acc_y_o     = acc_y_q;

  // A tick item starts the multiply sequence and advances the phase by one step.
  a_go_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (state_q == ST_MUL1) && (phase_q == $past(phase_sum[PHASE_BITS-1:0])))
    else $error("phase or state wrong after an accepted tick");

  // An item with tick clear leaves the phase alone and starts nothing.
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !tick_i) |=> $stable(phase_q) && (state_q == ST_IDLE))
    else $error("tick-clear item changed the state");

  // A new result only appears from the rounding stage.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside the rounding stage");

  // The rounding stage holds while the output register is full and stalled.
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && out_stall_i) |=> (state_q == ST_FIN))
    else $error("result dropped while the output was stalled");

endmodule

// ===== tb/circle_point_checker.sv =====
`timescale 1ns / 1ps
// Checker for the circle trajectory generator: follows register writes and both item channels,
// predicts every point from its own quarter-wave sine table and compares it field by field.
// Depends on ctg_pkg for the register index names and widths.
module circle_point_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ctg_pkg::CfgAddrBits-1:0] cfg_addr_i,
  input  logic [ctg_pkg::CfgDataBits-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            tick_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic signed [16:0]              pos_x_i,
  input  logic signed [16:0]              pos_y_i,
  input  logic signed [15:0]              pos_z_i,
  input  logic signed [23:0]              vel_x_i,
  input  logic signed [23:0]              vel_y_i,
  input  logic signed [23:0]              acc_x_i,
  input  logic signed [23:0]              acc_y_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  import ctg_pkg::*;

  localparam int unsigned LutBits   = 10;
  localparam int unsigned LutSize   = 1 << LutBits;
  localparam logic [63:0] QuarterQ30 = 64'd1686629713;
  localparam logic [63:0] PosLimit  = 64'd65535;
  localparam logic [63:0] RateLimit = 64'd8388607;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] acc_x;
    logic signed [23:0] acc_y;
  } circle_point_t;

  logic [15:0]   sine_lut [LutSize];
  logic [31:0]   phase_acc;
  logic [31:0]   step_reg;
  logic [15:0]   radius_reg;
  logic [15:0]   altitude_reg;
  logic [15:0]   rate_reg;
  circle_point_t pending_points [$];
  int unsigned   errors;
  int unsigned   checked;

  // Sine in unsigned Q30 by a nine-term Taylor series, truncating after each term.
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x_sq;
    logic [63:0] term;
    logic [63:0] acc;
    int unsigned n;
    x_sq = (x * x) >> 30;
    term = x;
    acc  = x;
    for (n = 1; n <= 8; n++) begin
      term = ((term * x_sq) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  initial begin
    logic [63:0] arg;
    logic [63:0] val;
    for (int unsigned k = 0; k < LutSize; k++) begin
      arg = (QuarterQ30 * (64'(2 * k) + 64'd1)) >> (LutBits + 1);
      val = (sine_q30(arg) + 64'd16384) >> 15;
      sine_lut[k] = val[15:0];
    end
  end

  // Rounds half away from zero and clamps the magnitude to lim, or lim+1 when negative.
  function automatic logic [63:0] round_clamp(input logic [63:0] mag, input int unsigned shift,
                                              input logic neg, input logic [63:0] lim);
    logic [63:0] r;
    r = (mag + (64'd1 << (shift - 1))) >> shift;
    if (neg) begin
      if (r > lim + 64'd1) begin
        r = lim + 64'd1;
      end
      r = 64'd0 - r;
    end else if (r > lim) begin
      r = lim;
    end
    return r;
  endfunction

  function automatic circle_point_t predict_point(input logic [31:0] phase);
    circle_point_t p;
    logic [1:0]    quadrant;
    logic [9:0]    k;
    logic [9:0]    k_mirror;
    logic [63:0]   s_mag;
    logic [63:0]   c_mag;
    logic          s_neg;
    logic          c_neg;
    logic [63:0]   r;
    logic [63:0]   rw;
    logic [63:0]   rww;
    quadrant = phase[31:30];
    k        = phase[29:20];
    k_mirror = 10'd1023 - k;
    s_mag    = quadrant[0] ? 64'(sine_lut[k_mirror]) : 64'(sine_lut[k]);
    c_mag    = quadrant[0] ? 64'(sine_lut[k]) : 64'(sine_lut[k_mirror]);
    s_neg    = quadrant[1];
    // Cosine is negative in the second and third quadrants.
    c_neg    = quadrant[1] ^ quadrant[0];
    r        = 64'(radius_reg);
    rw       = r * 64'(rate_reg);
    rww      = rw * 64'(rate_reg);
    p.pos_x  = 17'(round_clamp(r * c_mag, 15, c_neg, PosLimit));
    p.pos_y  = 17'(round_clamp(r * s_mag, 15, s_neg, PosLimit));
    p.pos_z  = altitude_reg;
    p.vel_x  = 24'(round_clamp(rw * s_mag, 27, !s_neg, RateLimit));
    p.vel_y  = 24'(round_clamp(rw * c_mag, 27, c_neg, RateLimit));
    p.acc_x  = 24'(round_clamp(rww * c_mag, 39, !c_neg, RateLimit));
    p.acc_y  = 24'(round_clamp(rww * s_mag, 39, !s_neg, RateLimit));
    return p;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 10) begin
        $display("point %0d: %s expected %0d, got %0d", checked, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    circle_point_t want;
    circle_point_t got;
    if (!rst_ni) begin
      phase_acc    = 32'd0;
      step_reg     = 32'd2050696;
      radius_reg   = 16'd512;
      altitude_reg = 16'd512;
      rate_reg     = 16'd1229;
      pending_points.delete();
      errors       = 0;
      checked      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_PHASE_STEP: step_reg     = cfg_wdata_i;
          CFG_RADIUS:     radius_reg   = cfg_wdata_i[15:0];
          CFG_ALTITUDE:   altitude_reg = cfg_wdata_i[15:0];
          CFG_ANGLE_RATE: rate_reg     = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got.pos_x = pos_x_i;
        got.pos_y = pos_y_i;
        got.pos_z = pos_z_i;
        got.vel_x = vel_x_i;
        got.vel_y = vel_y_i;
        got.acc_x = acc_x_i;
        got.acc_y = acc_y_i;
        if (pending_points.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected point: x %0d y %0d z %0d", pos_x_i, pos_y_i, pos_z_i);
          end
        end else begin
          want = pending_points.pop_front();
          check_field("pos_x", want.pos_x, got.pos_x);
          check_field("pos_y", want.pos_y, got.pos_y);
          check_field("pos_z", want.pos_z, got.pos_z);
          check_field("vel_x", want.vel_x, got.vel_x);
          check_field("vel_y", want.vel_y, got.vel_y);
          check_field("acc_x", want.acc_x, got.acc_x);
          check_field("acc_y", want.acc_y, got.acc_y);
          checked++;
        end
      end
      // An item with tick clear is taken but leaves the phase alone.
      if (in_valid_i && !in_stall_i && tick_i) begin
        pending_points.push_back(predict_point(phase_acc));
        phase_acc = phase_acc + step_reg;
      end
    end
    fail_count_o = errors;
    pending_o    = pending_points.size();
    checked_o    = checked;
  end

endmodule

// ===== tb/circle_trajectory_generator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the circle trajectory generator: drives register writes and tick items
// under several idling patterns and reports the verdict. Depends on ctg_pkg, the block and
// circle_point_checker.
module circle_trajectory_generator_tb;
  import ctg_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned PhaseItems    = 115;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgAddrBits-1:0] cfg_addr_i  = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   tick_i      = 1'b0;
  logic                   out_stall_i = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic signed [16:0]     pos_x_o;
  logic signed [16:0]     pos_y_o;
  logic signed [15:0]     pos_z_o;
  logic signed [23:0]     vel_x_o;
  logic signed [23:0]     vel_y_o;
  logic signed [23:0]     acc_x_o;
  logic signed [23:0]     acc_y_o;

  int unsigned fail_count;
  int unsigned points_pending;
  int unsigned points_checked;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned ticks_sent     = 0;
  int unsigned blank_ticks    = 0;
  int unsigned settings_count = 0;

  circle_trajectory_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .tick_i      (tick_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .vel_x_o     (vel_x_o),
    .vel_y_o     (vel_y_o),
    .acc_x_o     (acc_x_o),
    .acc_y_o     (acc_y_o)
  );

  circle_point_checker point_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .tick_i       (tick_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_i      (pos_x_o),
    .pos_y_i      (pos_y_o),
    .pos_z_i      (pos_z_o),
    .vel_x_i      (vel_x_o),
    .vel_y_i      (vel_y_o),
    .acc_x_i      (acc_x_o),
    .acc_y_i      (acc_y_o),
    .fail_count_o (fail_count),
    .pending_o    (points_pending),
    .checked_o    (points_checked)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_tick(input logic tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= tick;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
    if (!tick) begin
      blank_ticks++;
    end
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (points_pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // Registers change only once the block has gone quiet, including after blank ticks.
  task automatic apply_settings(input logic [31:0] step, input logic [15:0] radius,
                                input logic [15:0] altitude, input logic [15:0] rate);
    hold_until_drained();
    repeat (SettleCycles) @(negedge clk_i);
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_RADIUS, {16'h0000, radius});
    write_reg(CFG_ALTITUDE, {16'h0000, altitude});
    write_reg(CFG_ANGLE_RATE, {16'h0000, rate});
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  task automatic apply_random_settings();
    logic [31:0] step;
    logic [15:0] radius;
    logic [15:0] altitude;
    logic [15:0] rate;
    case ($urandom_range(4))
      0:       step = 32'h0000_0000;
      1:       step = 32'hFFFF_FFFF;
      2:       step = $urandom_range(32'h0100_0000);
      default: step = $urandom;
    endcase
    case ($urandom_range(3))
      0:       radius = 16'h0000;
      1:       radius = 16'hFFFF;
      default: radius = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0:       altitude = 16'h8000;
      1:       altitude = 16'h7FFF;
      default: altitude = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0:       rate = 16'h0000;
      1:       rate = 16'hFFFF;
      2:       rate = 16'($urandom_range(8192));
      default: rate = 16'($urandom);
    endcase
    apply_settings(step, radius, altitude, rate);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings from phase zero, with a blank tick that must not move the phase.
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    // Quarter-turn steps visit each quadrant near its boundary with full radius and rate, so
    // the acceleration saturates in both directions.
    apply_settings(32'h4000_0000, 16'hFFFF, 16'h8000, 16'hFFFF);
    repeat (5) send_tick(1'b1);
    // Zero radius and rate with the largest step, which walks the phase backwards.
    apply_settings(32'hFFFF_FFFF, 16'h0000, 16'h7FFF, 16'h0000);
    repeat (3) send_tick(1'b1);
    // A step one index short of a quarter walks the index down past zero to the last entry.
    apply_settings(32'h3FF0_0000, 16'hFFFF, 16'h0000, 16'h1000);
    repeat (6) send_tick(1'b1);
    hold_until_drained();
    apply_settings(32'h0000_0000, 16'h1234, 16'hFFFF, 16'h0001);
    repeat (2) send_tick(1'b1);

    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      apply_random_settings();
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(39) == 0) begin
          hold_until_drained();
        end
        send_tick($urandom_range(19) != 0);
      end
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (points_pending != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
    $display("Sent %0d tick items, %0d of them blank, under %0d register settings.",
             ticks_sent, blank_ticks, settings_count);
    $display("Compared %0d points across all idling patterns.", points_checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
